// ===== sv/rmst_pkg.sv =====
// Shared types, constants and helpers of the range-maximum segment tree.
// Depends on nothing; used by every module of the block.
package rmst_pkg;

	localparam int DATA_W     = 32;
	localparam int POS_W      = 10;
	localparam int CFG_W      = 11;
	localparam int IN_TDATA_W = 64;

	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

	// Field offsets inside the slave-side tdata, lowest field first
	localparam int WPOS_LSB = 0;
	localparam int WVAL_LSB = WPOS_LSB + POS_W;
	localparam int RLO_LSB  = WVAL_LSB + DATA_W;
	localparam int RHI_LSB  = RLO_LSB + POS_W;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [POS_W-1:0]         pos_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	localparam data_t MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		cmd_t  cmd;
		pos_t  write_position;
		data_t write_value;
		pos_t  range_low;
		pos_t  range_high;
	} req_t;

	typedef struct packed {
		data_t max_value;
		logic  range_error;
	} res_t;

	function automatic data_t larger(input data_t a, input data_t b);
		return (a >= b) ? a : b;
	endfunction

endpackage

// ===== sv/rmst_mem.sv =====
// Tree node store: one write port and one read port, registered read data.
// Depends on rmst_pkg for the data type.
module rmst_mem #(
	parameter int AW = 11
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  rmst_pkg::data_t     wdata,
	input  logic [AW-1:0]       raddr,
	output rmst_pkg::data_t     rdata_q
);

	rmst_pkg::data_t mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

// ===== sv/rmst_walk.sv =====
// Sequencer of the segment tree: clearing pass, leaf-to-root update, range walk.
// Depends on rmst_pkg; drives the ports of rmst_mem.
module rmst_walk #(
	parameter int LEAVES = 1024,
	parameter int AW     = $clog2(LEAVES) + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  rmst_pkg::req_t               req,
	input  logic [rmst_pkg::CFG_W-1:0]   size_in_use,
	output logic                         ready,
	output logic                         res_valid,
	output rmst_pkg::res_t               res,
	input  logic                         res_ready,
	output logic                         mem_we,
	output logic [AW-1:0]                mem_waddr,
	output rmst_pkg::data_t              mem_wdata,
	output logic [AW-1:0]                mem_raddr,
	input  rmst_pkg::data_t              mem_rdata
);

	localparam int LW = AW - 1;
	localparam int NW = AW + 1;
	localparam int CW = (LW + 1 > rmst_pkg::CFG_W) ? LW + 1 : rmst_pkg::CFG_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UP,
		ST_QLO,
		ST_QHI,
		ST_DONE
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   clr_q;
	logic [AW-1:0]   node_q;
	rmst_pkg::data_t val_q;
	logic [NW-1:0]   lo_q;
	logic [NW-1:0]   hi_q;
	rmst_pkg::data_t best_q;
	logic            err_q;
	logic            pend_q;

	logic [CW-1:0]   leaves_c;
	logic [CW-1:0]   size_w;
	logic [CW-1:0]   size_eff;
	logic [CW-1:0]   pos_w;
	logic [CW-1:0]   lo_w;
	logic [CW-1:0]   hi_w;
	logic            wr_ok;
	logic            q_err;
	logic [AW-1:0]   leaf_addr;
	logic [NW-1:0]   lo_start;
	logic [NW-1:0]   hi_start;
	logic [AW-1:0]   parent;
	rmst_pkg::data_t up_val;
	rmst_pkg::data_t best_acc;

	assign leaves_c  = CW'(LEAVES);
	assign size_w    = CW'(size_in_use);
	assign size_eff  = (size_w > leaves_c) ? leaves_c : size_w;
	assign pos_w     = CW'(req.write_position);
	assign lo_w      = CW'(req.range_low);
	assign hi_w      = CW'(req.range_high);
	assign wr_ok     = pos_w < size_eff;
	assign q_err     = (lo_w > hi_w) || (hi_w >= size_eff);
	assign leaf_addr = {1'b1, pos_w[LW-1:0]};
	assign lo_start  = NW'({1'b1, lo_w[LW-1:0]});
	assign hi_start  = NW'({1'b1, hi_w[LW-1:0]}) + NW'(1);
	assign parent    = node_q >> 1;
	assign up_val    = rmst_pkg::larger(val_q, mem_rdata);
	assign best_acc  = pend_q ? rmst_pkg::larger(best_q, mem_rdata) : best_q;

	assign ready           = (state_q == ST_IDLE);
	assign res_valid       = (state_q == ST_DONE);
	assign res.max_value   = best_q;
	assign res.range_error = err_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		mem_raddr = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				if (req_valid && req.cmd == rmst_pkg::CMD_WRITE && wr_ok) begin
					mem_we    = 1'b1;
					mem_waddr = leaf_addr;
					mem_wdata = req.write_value;
					mem_raddr = leaf_addr ^ AW'(1);
				end
			end
			ST_UP: begin
				mem_we    = 1'b1;
				mem_waddr = parent;
				mem_wdata = up_val;
				mem_raddr = parent ^ AW'(1);
			end
			ST_QLO: begin
				mem_raddr = lo_q[AW-1:0];
			end
			ST_QHI: begin
				mem_raddr = hi_q[AW-1:0] - AW'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						if (req.cmd == rmst_pkg::CMD_WRITE) begin
							if (wr_ok) begin
								node_q  <= leaf_addr;
								val_q   <= req.write_value;
								state_q <= ST_UP;
							end
						end else if (q_err) begin
							best_q  <= '0;
							err_q   <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							lo_q    <= lo_start;
							hi_q    <= hi_start;
							best_q  <= rmst_pkg::MOST_NEG;
							err_q   <= 1'b0;
							pend_q  <= 1'b0;
							state_q <= ST_QLO;
						end
					end
				end
				ST_UP: begin
					node_q <= parent;
					val_q  <= up_val;
					if (parent == AW'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_QLO: begin
					best_q <= best_acc;
					if (lo_q < hi_q) begin
						pend_q <= lo_q[0];
						if (lo_q[0]) begin
							lo_q <= lo_q + NW'(1);
						end
						state_q <= ST_QHI;
					end else begin
						pend_q  <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_QHI: begin
					// an odd right bound steps down by one; the halving absorbs it
					best_q  <= best_acc;
					pend_q  <= hi_q[0];
					lo_q    <= lo_q >> 1;
					hi_q    <= hi_q >> 1;
					state_q <= ST_QLO;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/range_max_segment_tree.sv =====
// Top level of the range-maximum segment tree: stream ports, size register,
// result register. Depends on rmst_pkg, rmst_mem and rmst_walk.
//
// The block keeps LEAVES signed 32-bit values in a heap-ordered tree held in
// one memory of 2*LEAVES entries (one write and one registered read port).
// After reset it runs a clearing pass over all 2*LEAVES entries with
// s_axis_tready low; configuration writes are taken throughout. A write
// request (tuser 0) stores a leaf and walks up to the root, one level per
// cycle. A write beyond the size in use is dropped. A query request (tuser 1)
// walks both range bounds upward, two memory reads per level through the
// single read port; a bad range returns range_error with max_value 0. One
// request is in flight at a time; a finished result sits in the output
// register so the next request is accepted while it waits to be taken.
// size_in_use is written over the cfg channel (always ready); the user must
// write it only while idle, as the block itself does not enforce this.
// Values above LEAVES act as LEAVES.
module range_max_segment_tree #(
	parameter int LEAVES = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// cfg_data: size_in_use
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rmst_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// s_axis_tdata from bit 0: write_position[9:0], write_value[41:10],
	// range_low[51:42], range_high[61:52], zero fill[63:62]
	input  logic [rmst_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// s_axis_tuser: cmd
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// m_axis_tdata: max_value[31:0]
	output logic [rmst_pkg::DATA_W-1:0]         m_axis_tdata,
	// m_axis_tuser: range_error
	output logic                                m_axis_tuser
);

	localparam int AW = $clog2(LEAVES) + 1;

	logic [rmst_pkg::CFG_W-1:0] size_q;
	rmst_pkg::req_t             req;
	rmst_pkg::res_t             res;
	rmst_pkg::res_t             out_q;
	logic                       out_valid_q;
	logic                       walk_ready;
	logic                       res_valid;
	logic                       res_ready;
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	rmst_pkg::data_t            mem_wdata;
	logic [AW-1:0]              mem_raddr;
	rmst_pkg::data_t            mem_rdata;

	// Unpack the request fields
	assign req.cmd            = rmst_pkg::cmd_t'(s_axis_tuser);
	assign req.write_position = s_axis_tdata[rmst_pkg::WPOS_LSB +: rmst_pkg::POS_W];
	assign req.write_value    = s_axis_tdata[rmst_pkg::WVAL_LSB +: rmst_pkg::DATA_W];
	assign req.range_low      = s_axis_tdata[rmst_pkg::RLO_LSB +: rmst_pkg::POS_W];
	assign req.range_high     = s_axis_tdata[rmst_pkg::RHI_LSB +: rmst_pkg::POS_W];

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = walk_ready;

	// Hold size_in_use; it is to be written only while idle, which the block does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= rmst_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			size_q <= cfg_data;
		end
	end

	// Output register: load a finished result when empty or being drained
	assign res_ready     = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.max_value;
	assign m_axis_tuser  = out_q.range_error;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	rmst_walk #(
		.LEAVES (LEAVES),
		.AW     (AW)
	) u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (s_axis_tvalid),
		.req         (req),
		.size_in_use (size_q),
		.ready       (walk_ready),
		.res_valid   (res_valid),
		.res         (res),
		.res_ready   (res_ready),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	rmst_mem #(
		.AW (AW)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr   (mem_raddr),
		.rdata_q (mem_rdata)
	);

endmodule

// ===== sv/rmst_checker.sv =====
// Port-level checks of the range-maximum segment tree, bound to the top level.
// Depends on rmst_pkg for port widths.
module rmst_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             s_axis_tuser,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [rmst_pkg::DATA_W-1:0]      m_axis_tdata,
	input logic                             m_axis_tuser
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// An error result carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("error result with nonzero value");

	// A write request never brings a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !$rose(m_axis_tvalid))
		else $error("result appeared after a write request");

	// A query request keeps the block busy for at least the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
		else $error("accepted a request right after a query");

endmodule

bind range_max_segment_tree rmst_checker u_rmst_checker (.*);
